// ----- hw/rtl/hrc_pkg.sv -----
`default_nettype none

package hrc_pkg;

  localparam logic [7:0] CharZero    = 8'd48;
  localparam logic [7:0] CharNine    = 8'd57;
  localparam logic [7:0] AlphaOffset = 8'd55;
  localparam logic [7:0] LenBias     = 8'hB;

  localparam logic [7:0] TypeData    = 8'h30;  // '0'
  localparam logic [7:0] TypeEof     = 8'h31;  // '1'
  localparam logic [7:0] TypeExtLin  = 8'h34;  // '4'
  localparam logic [7:0] TypeStartLn = 8'h35;  // '5'

  localparam logic [7:0] PosLength   = 8'd2;
  localparam logic [7:0] PosType     = 8'd8;

  // Parser result for one transaction
  typedef struct packed {
    logic valid;
    logic ok;
  } result_t;

  // Decimal digits map to value, anything else to char - 55 mod 256
  function automatic logic [7:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    if (c >= CharZero && c <= CharNine) begin
      d = c - CharZero;
    end else begin
      d = c - AlphaOffset;
    end
    return d;
  endfunction

  function automatic logic type_ok(input logic [7:0] c);
    return (c == TypeData) || (c == TypeEof) || (c == TypeExtLin) || (c == TypeStartLn);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hrc_in_if.sv -----
`default_nettype none

interface hrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       record_start;

  modport source (output valid, output char_in, output record_start, input ready);
  modport sink   (input valid, input char_in, input record_start, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/hrc_out_if.sv -----
`default_nettype none

interface hrc_out_if;
  logic valid;
  logic ready;
  logic record_ok;

  modport source (output valid, output record_ok, input ready);
  modport sink   (input valid, input record_ok, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/hex_record_checksum_checker.sv -----
// Channel | Dir | Payload                   | Meaning
// in_i    | in  | char_in[7:0], record_start | one record character, start on colon
// out_o   | out | record_ok                  | type accepted and checksum matches
//
// One transaction per cycle while the result is not stalled: a character is registered,
// then decoded against the record state when it advances; the 8-bit checksum add and
// compare set that path. The result passes through the input and output registers.
// Reset clears the record state to idle; no record is in progress after reset.
// A stalled result holds in the output register; the input register keeps taking
// characters until it is full behind a stalled result.
`default_nettype none

module hex_record_checksum_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hrc_in_if.sink    in_i,
  hrc_out_if.source out_o
);

  logic       in_vld_q;
  logic [7:0] in_char_q;
  logic       in_start_q;
  logic       out_vld_q;
  logic       out_ok_q;
  logic       advance;
  logic       in_take;

  hrc_pkg::result_t res;

  assign advance   = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;
  assign in_take   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q  <= in_i.char_in;
      in_start_q <= in_i.record_start;
    end
  end

  hrc_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .char_i    (in_char_q),
    .start_i   (in_start_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res.valid) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_ok_q <= res.ok;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.record_ok = out_ok_q;

  // input stalls only behind a full input register and a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (in_vld_q && out_vld_q && !out_o.ready))
    else $error("input stalled without a blocked result");

  // a result comes only from a character that advances in this cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> advance)
    else $error("result without an advancing character");

  // every result lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |=> (out_vld_q && out_ok_q == $past(res.ok)))
    else $error("result lost on its way to the output");

endmodule

`default_nettype wire

// ----- hw/rtl/hrc_parser.sv -----
`default_nettype none

module hrc_parser (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            advance_i,
  input  wire logic [7:0]      char_i,
  input  wire logic            start_i,
  output hrc_pkg::result_t     res_o
);

  logic [7:0] pos_q, pos_d;
  logic [7:0] len_q, len_d;
  logic [7:0] held_q, held_d;
  logic [7:0] sum_q, sum_d;
  logic       type_q, type_d;
  logic       active_q, active_d;

  logic [7:0] p;
  logic [7:0] digit;
  logic [7:0] byte_val;
  logic [7:0] len_new;
  logic [7:0] len_eff;
  logic       emit;
  logic       ok;

  assign p        = pos_q + 8'd1;
  assign digit    = hrc_pkg::digit_of(char_i);
  assign byte_val = {held_q[3:0], 4'b0000} | digit;
  assign len_new  = {byte_val[6:0], 1'b0} + hrc_pkg::LenBias;
  assign len_eff  = (p == hrc_pkg::PosLength) ? len_new : len_q;

  always_comb begin
    pos_d    = pos_q;
    len_d    = len_q;
    held_d   = held_q;
    sum_d    = sum_q;
    type_d   = type_q;
    active_d = active_q;
    emit     = 1'b0;
    ok       = 1'b0;
    if (advance_i) begin
      priority if (start_i) begin
        pos_d    = '0;
        len_d    = '0;
        held_d   = '0;
        sum_d    = '0;
        type_d   = 1'b0;
        active_d = 1'b1;
      end else if (active_q) begin
        pos_d = p;
        if (p == hrc_pkg::PosType) begin
          type_d = hrc_pkg::type_ok(char_i);
        end
        if (p[0]) begin
          held_d = digit;
        end else begin
          if (p == hrc_pkg::PosLength) begin
            len_d = len_new;
          end
          // wrapped length: report invalid and drop the record
          if (p == hrc_pkg::PosLength && len_new < hrc_pkg::LenBias) begin
            active_d = 1'b0;
            emit     = 1'b1;
          end else begin
            if ({1'b0, p} + 9'd3 <= {1'b0, len_eff}) begin
              sum_d = sum_q + byte_val;
            end
            if ({1'b0, p} + 9'd1 == {1'b0, len_eff}) begin
              active_d = 1'b0;
              emit     = 1'b1;
              ok       = type_q && ((8'd0 - sum_q) == byte_val);
            end
          end
        end
      end else begin
        // idle: ignore characters outside a record
        active_d = active_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      len_q    <= '0;
      held_q   <= '0;
      sum_q    <= '0;
      type_q   <= 1'b0;
      active_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      len_q    <= len_d;
      held_q   <= held_d;
      sum_q    <= sum_d;
      type_q   <= type_d;
      active_q <= active_d;
    end
  end

  assign res_o.valid = emit;
  assign res_o.ok    = ok;

endmodule

`default_nettype wire
